@@ hw/rtl/hlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and constants of the heartbeat liveness table: field widths,
// status and register codes, controller states and the control/status
// bundles that run between controller and datapath.
// ----------------------------------------------------------------------------
package hlt_pkg;

   // field widths
   localparam int ID_W       = 31;
   localparam int TIME_W     = 64;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int ENTRY_W    = ID_W + TIME_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 2'd1;

   // register reset values
   localparam logic [COUNT_W-1:0] ENTRIES_RESET = 7'd64;

   // transaction modes
   localparam logic MODE_HEARTBEAT = 1'b0;
   localparam logic MODE_SWEEP     = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_REFRESHED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_CLAIMED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SWEPT     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_SWEEP_OFF = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 3'd5;

   // controller states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_DRAIN,
      S_COMMIT,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_write;
      logic load_req;
      logic scan_read;
      logic commit;
      logic resp_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic skip_scan;
      logic out_free;
   } ctl_stat_type;

endpackage

@@ hw/rtl/hlt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module hlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/hlt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_ctrl
// Sequencer of the liveness table: clearing pass after reset, then per
// transaction a dispatch, a scan over the active slots, a drain and a commit
// (skipped when no scan is needed) and the hand-over to the result register.
// ----------------------------------------------------------------------------
module hlt_ctrl
   import hlt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.skip_scan) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   // clearing pass only ever ends in idle
   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |=> state_ff == S_CLEAR || state_ff == S_IDLE)
      else $error("clearing pass left to a state other than idle");

   // commit is a single cycle followed by the response
   a_commit_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT |=> state_ff == S_RESP)
      else $error("commit not followed by response");

endmodule

@@ hw/rtl/hlt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_datapath
// Configuration registers, request capture, slot scan with id match, free
// slot search and age compare, table memory and the result register.
// ----------------------------------------------------------------------------
module hlt_datapath
   import hlt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // request payload
   input  logic                  req_mode,
   input  logic [ID_W-1:0]       req_client_id,
   input  logic [TIME_W-1:0]     req_now_time,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   output logic [COUNT_W-1:0]    rsp_evicted_count,
   // controller
   input  ctl_cmd_type           cmd,
   output ctl_stat_type          stat
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // configuration registers
   logic [TIME_W-1:0]  timeout_ff;
   logic [COUNT_W-1:0] entries_ff;

   // captured transaction
   logic               req_mode_ff;
   logic [ID_W-1:0]    req_id_ff;
   logic [TIME_W-1:0]  req_now_ff;

   // scan state
   logic [ADDR_W-1:0]  addr_ff;
   logic               rd_valid_ff;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic               match_found_ff;
   logic               free_found_ff;
   logic [ADDR_W-1:0]  match_idx_ff;
   logic [ADDR_W-1:0]  free_idx_ff;
   logic [CNT_W-1:0]   evict_cnt_ff;

   // result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]  rsp_evicted_ff;

   // combinational
   logic [CMP_W-1:0]    ent_ext;
   logic [CMP_W-1:0]    depth_ext;
   logic [CNT_W-1:0]    active_n;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [ID_W-1:0]     rd_id;
   logic [TIME_W-1:0]   rd_last;
   logic [TIME_W-1:0]   age;
   logic                is_hb;
   logic                evict_now;
   logic                hit_now;
   logic                free_now;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [STATUS_W-1:0] status_in;
   logic [ADDR_W-1:0]   result_idx;
   logic [ADDR_W+SLOT_W-1:0]  slot_wide;
   logic [CNT_W+COUNT_W-1:0]  evict_wide;

   // active slot count, saturated to the table depth
   assign ent_ext   = CMP_W'(entries_ff);
   assign depth_ext = CMP_W'(TABLE_DEPTH);
   assign active_n  = (ent_ext > depth_ext) ? CNT_W'(depth_ext) : CNT_W'(ent_ext);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= '0;
         entries_ff <= ENTRIES_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TIMEOUT_LIMIT:  timeout_ff <= csr_data;
            CSR_ENTRIES_IN_USE: entries_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_mode_ff <= req_mode;
         req_id_ff   <= req_client_id;
         req_now_ff  <= req_now_time;
      end
   end

   // slot counter shared by clearing pass and scan
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (cmd.load_req) begin
         addr_ff <= '0;
      end else if (cmd.clear_write || cmd.scan_read) begin
         addr_ff <= addr_ff + ADDR_W'(1);
      end
   end

   // read data tracking, registered to line up with the memory read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_read;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= addr_ff;
   end

   // slot compare
   assign rd_id     = ram_rd_data[ENTRY_W-1:TIME_W];
   assign rd_last   = ram_rd_data[TIME_W-1:0];
   assign age       = req_now_ff - rd_last;
   assign is_hb     = (req_mode_ff == MODE_HEARTBEAT);
   assign hit_now   = rd_valid_ff && is_hb && (rd_id == req_id_ff);
   assign free_now  = rd_valid_ff && is_hb && (rd_id == '0);
   assign evict_now = rd_valid_ff && !is_hb && (rd_id != '0) && (age > timeout_ff);

   // first match, first free slot and eviction count
   always_ff @(posedge clock) begin
      if (reset || cmd.load_req) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         evict_cnt_ff   <= '0;
      end else begin
         if (hit_now && !match_found_ff) begin
            match_found_ff <= 1'b1;
         end
         if (free_now && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (evict_now) begin
            evict_cnt_ff <= evict_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit_now && !match_found_ff) begin
         match_idx_ff <= rd_addr_ff;
      end
      if (free_now && !free_found_ff) begin
         free_idx_ff <= rd_addr_ff;
      end
   end

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      priority if (cmd.clear_write) begin
         wr_en = 1'b1;
      end else if (evict_now) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr_ff;
      end else if (cmd.commit && is_hb && (match_found_ff || free_found_ff)) begin
         wr_en   = 1'b1;
         wr_addr = match_found_ff ? match_idx_ff : free_idx_ff;
         wr_data = {req_id_ff, req_now_ff};
      end else begin
         wr_en = 1'b0;
      end
   end

   hlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.scan_read),
      .rd_addr(addr_ff),
      .rd_data(ram_rd_data)
   );

   // result selection
   always_comb begin
      result_idx = '0;
      priority if (is_hb && (req_id_ff == '0)) begin
         status_in = STATUS_BAD_ID;
      end else if (!is_hb && (timeout_ff == '0)) begin
         status_in = STATUS_SWEEP_OFF;
      end else if (!is_hb) begin
         status_in = STATUS_SWEPT;
      end else if (match_found_ff) begin
         status_in  = STATUS_REFRESHED;
         result_idx = match_idx_ff;
      end else if (free_found_ff) begin
         status_in  = STATUS_CLAIMED;
         result_idx = free_idx_ff;
      end else begin
         status_in = STATUS_FULL;
      end
   end

   // fit slot and count to the field widths
   assign slot_wide  = {{SLOT_W{1'b0}}, result_idx};
   assign evict_wide = {{COUNT_W{1'b0}}, evict_cnt_ff};

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_status_ff  <= status_in;
         rsp_slot_ff    <= slot_wide[SLOT_W-1:0];
         rsp_evicted_ff <= (status_in == STATUS_SWEPT) ? evict_wide[COUNT_W-1:0] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_evicted_count = rsp_evicted_ff;

   // status to controller
   assign stat.clear_last = (addr_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign stat.scan_last  = (CNT_W'(addr_ff) == (active_n - CNT_W'(1)));
   assign stat.skip_scan  = (is_hb && (req_id_ff == '0)) ||
                            (!is_hb && (timeout_ff == '0)) ||
                            (active_n == '0);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // clearing pass owns the write port
   a_wr_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_write |-> !evict_now && !cmd.commit)
      else $error("table write port contention during clearing pass");

   // slot hits only come from heartbeats
   a_hit_mode: assert property (@(posedge clock) disable iff (reset)
      (match_found_ff || free_found_ff) |-> req_mode_ff == MODE_HEARTBEAT)
      else $error("slot hit recorded for a sweep");

endmodule

@@ hw/rtl/heartbeat_liveness_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_liveness_table_core
// Client liveness table: heartbeats refresh or claim slots, sweeps evict
// entries older than the configured timeout.
// ----------------------------------------------------------------------------
// Usage
// - request channel (req_*): mode, client id and current timestamp; a
//   transaction is taken when req_valid is high and req_stall is low.
// - result channel (rsp_*): status, slot index and eviction count, one per
//   request, held stable in an output register while rsp_stall is high.
// - csr_* writes timeout_limit (index 0) or entries_in_use (index 1); write
//   only while the block is idle.
// - after reset the table memory is cleared one slot per cycle, and
//   req_stall stays high until that pass is over; configuration writes are
//   taken during that pass.
// - one request at a time: a transaction passes dispatch, a scan of the n
//   active slots, a drain, a commit and the result hand-over before the next
//   request is taken; the scan is set by the single read port of the table
//   memory, one slot per cycle. Invalid ids, disabled sweeps and an active
//   count of zero go from dispatch straight to the result hand-over.
// - a stalled result does not block acceptance of the next request; only
//   its final hand-over waits for the output register to free up.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table_core
   import hlt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [ID_W-1:0]       req_client_id,
   input  logic [TIME_W-1:0]     req_now_time,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   output logic [COUNT_W-1:0]    rsp_evicted_count
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // sequencer
   hlt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   // table, compare and result datapath
   hlt_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_mode         (req_mode),
      .req_client_id    (req_client_id),
      .req_now_time     (req_now_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_evicted_count(rsp_evicted_count),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
